// ----- hw/rtl/integer_to_ascii_converter_defines.svh -----
// Assertion macros used by the converter's datapath module.
`ifndef INTEGER_TO_ASCII_CONVERTER_DEFINES_SVH
`define INTEGER_TO_ASCII_CONVERTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2A_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define I2A_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/i2a_pkg.sv -----
package i2a_pkg;

	localparam logic [1:0] OP_SDEC = 2'd0;
	localparam logic [1:0] OP_UDEC = 2'd1;
	localparam logic [1:0] OP_HEXL = 2'd2;
	localparam logic [1:0] OP_HEXU = 2'd3;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_LX    = 8'h78;
	localparam logic [7:0] CHAR_UX    = 8'h58;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_UA    = 8'h41;

	localparam logic [3:0] DEC_DIGITS = 4'd10;
	localparam logic [3:0] HEX_DIGITS = 4'd8;
	localparam logic [3:0] DEC_STEPS  = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_PFX0,
		ST_PFXX,
		ST_DIGITS
	} state_t;

	typedef enum logic [1:0] {
		EMIT_MINUS,
		EMIT_ZERO,
		EMIT_X,
		EMIT_DIGIT
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      dabble;
		logic      skip;
		logic      emit_en;
		emit_sel_t emit_sel;
	} cmd_t;

	typedef struct packed {
		logic hex;
		logic neg;
		logic top_zero;
		logic cnt_one;
		logic step_last;
		logic slot_free;
	} stat_t;

	function automatic logic [7:0] digit_char(input logic [3:0] n, input logic upper);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = CHAR_ZERO + {4'd0, n};
		end else begin
			c = (upper ? CHAR_UA : CHAR_LA) + {4'd0, n} - 8'd10;
		end
		return c;
	endfunction

	// Four shift-and-add-three steps of the binary to BCD conversion.
	function automatic logic [39:0] dabble4(input logic [39:0] bcd, input logic [3:0] bits);
		logic [39:0] b;
		logic [3:0]  bb;
		b  = bcd;
		bb = bits;
		for (int s = 0; s < 4; s++) begin
			for (int d = 0; d < 10; d++) begin
				if (b[d*4 +: 4] >= 4'd5) begin
					b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
				end
			end
			b  = {b[38:0], bb[3]};
			bb = {bb[2:0], 1'b0};
		end
		return b;
	endfunction

endpackage

// ----- hw/rtl/i2a_ctrl.sv -----
module i2a_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  i2a_pkg::stat_t stat,
	output i2a_pkg::cmd_t  cmd
);

	i2a_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2a_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.dabble   = 1'b0;
		cmd.skip     = 1'b0;
		cmd.emit_en  = 1'b0;
		cmd.emit_sel = i2a_pkg::EMIT_DIGIT;
		case (state_q)
			i2a_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
				end
			end
			i2a_pkg::ST_CONV: begin
				cmd.dabble = 1'b1;
				if (stat.step_last) begin
					state_d = i2a_pkg::ST_SKIP;
				end
			end
			i2a_pkg::ST_SKIP: begin
				if (stat.top_zero && !stat.cnt_one) begin
					cmd.skip = 1'b1;
				end else if (stat.neg) begin
					state_d = i2a_pkg::ST_SIGN;
				end else begin
					state_d = i2a_pkg::ST_DIGITS;
				end
			end
			i2a_pkg::ST_SIGN: begin
				if (stat.slot_free) begin
					cmd.emit_en  = 1'b1;
					cmd.emit_sel = i2a_pkg::EMIT_MINUS;
					state_d      = i2a_pkg::ST_DIGITS;
				end
			end
			i2a_pkg::ST_PFX0: begin
				if (stat.slot_free) begin
					cmd.emit_en  = 1'b1;
					cmd.emit_sel = i2a_pkg::EMIT_ZERO;
					state_d      = i2a_pkg::ST_PFXX;
				end
			end
			i2a_pkg::ST_PFXX: begin
				if (stat.slot_free) begin
					cmd.emit_en  = 1'b1;
					cmd.emit_sel = i2a_pkg::EMIT_X;
					state_d      = i2a_pkg::ST_DIGITS;
				end
			end
			i2a_pkg::ST_DIGITS: begin
				if (stat.slot_free) begin
					cmd.emit_en  = 1'b1;
					cmd.emit_sel = i2a_pkg::EMIT_DIGIT;
					if (stat.cnt_one) begin
						state_d = i2a_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = i2a_pkg::ST_IDLE;
			end
		endcase
		// The mode is only known in the datapath once the input is taken.
		if (state_q == i2a_pkg::ST_IDLE && s_tvalid) begin
			state_d = i2a_pkg::ST_CONV;
		end
		if (state_q == i2a_pkg::ST_PFX0 && !stat.hex) begin
			state_d = i2a_pkg::ST_CONV;
		end
		if (state_q == i2a_pkg::ST_CONV && stat.hex) begin
			cmd.dabble = 1'b0;
			state_d    = i2a_pkg::ST_PFX0;
		end
	end

endmodule

// ----- hw/rtl/i2a_datapath.sv -----
`include "integer_to_ascii_converter_defines.svh"

module i2a_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  i2a_pkg::cmd_t  cmd,
	output i2a_pkg::stat_t stat,
	input  logic [31:0]    s_tdata,
	input  logic [1:0]     s_tuser,
	input  logic           m_tready,
	output logic           m_tvalid,
	output logic [7:0]     m_tdata,
	output logic           m_tlast
);

	logic        hex_q;
	logic        upper_q;
	logic        neg_q;
	logic [31:0] bin_q;
	logic [39:0] digits_q;
	logic [3:0]  cnt_q;
	logic [3:0]  step_q;
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	logic        m_tlast_q;
	logic        in_neg;
	logic [3:0]  top;
	logic [7:0]  emit_char;

	assign in_neg = (s_tuser == i2a_pkg::OP_SDEC) && s_tdata[31];
	assign top    = digits_q[39:36];

	always_comb begin
		case (cmd.emit_sel)
			i2a_pkg::EMIT_MINUS: emit_char = i2a_pkg::CHAR_MINUS;
			i2a_pkg::EMIT_ZERO:  emit_char = i2a_pkg::CHAR_ZERO;
			i2a_pkg::EMIT_X:     emit_char = upper_q ? i2a_pkg::CHAR_UX : i2a_pkg::CHAR_LX;
			default:             emit_char = i2a_pkg::digit_char(top, upper_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			step_q <= '0;
		end else if (cmd.load) begin
			if (s_tuser[1]) begin
				cnt_q  <= i2a_pkg::HEX_DIGITS;
				step_q <= '0;
			end else begin
				cnt_q  <= i2a_pkg::DEC_DIGITS;
				step_q <= i2a_pkg::DEC_STEPS;
			end
		end else begin
			if (cmd.dabble) begin
				step_q <= step_q - 4'd1;
			end
			if (cmd.skip || (cmd.emit_en && cmd.emit_sel == i2a_pkg::EMIT_DIGIT)) begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hex_q   <= s_tuser[1];
			upper_q <= (s_tuser == i2a_pkg::OP_HEXU);
			neg_q   <= in_neg;
			bin_q   <= in_neg ? (~s_tdata + 32'd1) : s_tdata;
			digits_q <= s_tuser[1] ? {s_tdata, 8'h00} : 40'd0;
		end else if (cmd.dabble) begin
			digits_q <= i2a_pkg::dabble4(digits_q, bin_q[31:28]);
			bin_q    <= {bin_q[27:0], 4'h0};
		end else if (cmd.skip || (cmd.emit_en && cmd.emit_sel == i2a_pkg::EMIT_DIGIT)) begin
			digits_q <= {digits_q[35:0], 4'h0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_en) begin
			m_tdata_q <= emit_char;
			m_tlast_q <= (cmd.emit_sel == i2a_pkg::EMIT_DIGIT) && (cnt_q == 4'd1);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	assign stat.hex       = hex_q;
	assign stat.neg       = neg_q;
	assign stat.top_zero  = (top == 4'd0);
	assign stat.cnt_one   = (cnt_q == 4'd1);
	assign stat.step_last = (step_q == 4'd1);
	assign stat.slot_free = !m_tvalid_q || m_tready;

	`I2A_ASSERT_IMP(a_no_overwrite, cmd.emit_en, !m_tvalid_q || m_tready, "character overwritten")
	`I2A_ASSERT_IMP(a_digit_left, cmd.emit_en && cmd.emit_sel == i2a_pkg::EMIT_DIGIT, cnt_q != 4'd0, "digit emitted with none left")
	`I2A_ASSERT_IMP(a_step_left, cmd.dabble, step_q != 4'd0, "conversion step beyond the last")
	`I2A_ASSERT_IMP(a_dec_digit, cmd.emit_en && cmd.emit_sel == i2a_pkg::EMIT_DIGIT && !hex_q, top < 4'd10, "decimal digit out of range")
	`I2A_ASSERT_NXT(a_hex_len, cmd.load && s_tuser[1], cnt_q == i2a_pkg::HEX_DIGITS, "hex digit count wrong")

endmodule

// ----- hw/rtl/integer_to_ascii_converter.sv -----
// Hexadecimal: after acceptance the controller passes the conversion state, emits the prefix,
// then one character a cycle; ten characters per item.
// Decimal: DEC_STEPS steps of BCD conversion, then leading zeros are dropped,
// then one character a cycle, with a leading minus sign for a negative signed value.
// This rate holds while the output is never stalled; new input is taken only when idle.
// Reset clears the controller state, the output valid flag and the digit and step counters.
module integer_to_ascii_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // char_code[7:0]
	output logic        m_tlast
);

	i2a_pkg::cmd_t  cmd;
	i2a_pkg::stat_t stat;

	i2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	i2a_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- dv/integer_to_ascii_converter_checker.sv -----
`timescale 1ns / 1ps

module integer_to_ascii_converter_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic [1:0]  s_tuser,  // op[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,  // char_code[7:0]
	input  logic        m_tlast,
	output int          mismatches,
	output int          chars_pending,
	output int          numbers_seen,
	output int          chars_seen
);

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	text_char_t expected_chars[$];
	text_char_t oldest_char;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void predict_text(input logic [1:0] op, input logic [31:0] value);
		logic [7:0]  text[$];
		logic [7:0]  digits_rev[$];
		logic [31:0] mag;
		logic [31:0] rem;
		string       digit_set;
		text_char_t  entry;
		if (op == i2a_pkg::OP_HEXL || op == i2a_pkg::OP_HEXU) begin
			digit_set = (op == i2a_pkg::OP_HEXU) ? "0123456789ABCDEF" : "0123456789abcdef";
			text.push_back(i2a_pkg::CHAR_ZERO);
			text.push_back((op == i2a_pkg::OP_HEXU) ? i2a_pkg::CHAR_UX : i2a_pkg::CHAR_LX);
			for (int i = 7; i >= 0; i--) begin
				text.push_back(digit_set[value[i*4 +: 4]]);
			end
		end else begin
			mag = value;
			if (op == i2a_pkg::OP_SDEC && value[31]) begin
				text.push_back(i2a_pkg::CHAR_MINUS);
				mag = ~value + 32'd1;
			end
			do begin
				rem = mag % 32'd10;
				digits_rev.push_front(i2a_pkg::CHAR_ZERO + rem[7:0]);
				mag = mag / 32'd10;
			end while (mag != 32'd0);
			foreach (digits_rev[k]) begin
				text.push_back(digits_rev[k]);
			end
		end
		foreach (text[k]) begin
			entry.code = text[k];
			entry.last = (k == text.size() - 1);
			expected_chars.push_back(entry);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				chars_seen++;
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character 0x%02h with none expected", m_tdata));
				end else begin
					oldest_char = expected_chars.pop_front();
					if (m_tdata !== oldest_char.code) begin
						report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
							m_tdata, oldest_char.code));
					end
					if (m_tlast !== oldest_char.last) begin
						report_mismatch($sformatf("last %0b on char 0x%02h, expected %0b",
							m_tlast, oldest_char.code, oldest_char.last));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				numbers_seen++;
				predict_text(s_tuser, s_tdata);
			end
			chars_pending = expected_chars.size();
		end
	end

endmodule

// ----- dv/integer_to_ascii_converter_tb.sv -----
`timescale 1ns / 1ps

module integer_to_ascii_converter_tb;

	localparam int RANDOM_NUMBERS = 330;
	localparam int IDLE_LIMIT     = 2000;
	localparam int HOLD_START     = 1500;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 40;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = 32'd0;  // value[31:0]
	logic [1:0]  s_tuser  = i2a_pkg::OP_SDEC; // op[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;  // char_code[7:0]
	logic        m_tlast;

	int mismatches;
	int chars_pending;
	int numbers_seen;
	int chars_seen;
	int idle_cycles = 0;

	integer_to_ascii_converter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	integer_to_ascii_converter_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.mismatches    (mismatches),
		.chars_pending (chars_pending),
		.numbers_seen  (numbers_seen),
		.chars_seen    (chars_seen)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] p;
		int          n;
		case ($urandom_range(0, 5))
			0: begin
				return $urandom;
			end
			1: begin
				return $urandom_range(0, 999);
			end
			2: begin
				p = 32'd1;
				n = $urandom_range(0, 9);
				for (int i = 0; i < n; i++) begin
					p = p * 32'd10;
				end
				return p + $urandom_range(0, 2) - 32'd1;
			end
			3: begin
				case ($urandom_range(0, 3))
					0: p = 32'h8000_0000;
					1: p = 32'h7FFF_FFFF;
					2: p = 32'hFFFF_FFFF;
					default: p = 32'h0000_0000;
				endcase
				return p + $urandom_range(0, 4) - 32'd2;
			end
			4: begin
				return $urandom >> $urandom_range(0, 31);
			end
			default: begin
				return 32'd0 - $urandom_range(1, 100000);
			end
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_number(input logic [1:0] op, input logic [31:0] value);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= value;
		do begin
			@(posedge clk);
		end while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_with_gap(input logic [1:0] op, input logic [31:0] value);
		int gap;
		send_number(op, value);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			s_tuser  <= 2'($urandom_range(0, 3));
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_pause();
		s_tvalid <= 1'b0;
		while (chars_pending != 0) begin
			@(negedge clk);
		end
		@(negedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_with_gap(i2a_pkg::OP_SDEC, 32'h0000_0000);
		send_with_gap(i2a_pkg::OP_SDEC, 32'h0000_0001);
		send_with_gap(i2a_pkg::OP_SDEC, 32'hFFFF_FFFF);
		send_with_gap(i2a_pkg::OP_SDEC, 32'h7FFF_FFFF);
		send_with_gap(i2a_pkg::OP_SDEC, 32'h8000_0000);
		send_with_gap(i2a_pkg::OP_SDEC, 32'd9);
		send_with_gap(i2a_pkg::OP_SDEC, 32'd10);
		send_with_gap(i2a_pkg::OP_SDEC, 32'hFFFF_FFF6);
		send_with_gap(i2a_pkg::OP_UDEC, 32'h0000_0000);
		send_with_gap(i2a_pkg::OP_UDEC, 32'hFFFF_FFFF);
		send_with_gap(i2a_pkg::OP_UDEC, 32'h8000_0000);
		send_with_gap(i2a_pkg::OP_UDEC, 32'd1000000000);
		send_with_gap(i2a_pkg::OP_UDEC, 32'd999999999);
		send_with_gap(i2a_pkg::OP_UDEC, 32'd9);
		send_with_gap(i2a_pkg::OP_HEXL, 32'h0000_0000);
		send_with_gap(i2a_pkg::OP_HEXL, 32'hFFFF_FFFF);
		send_with_gap(i2a_pkg::OP_HEXL, 32'h89AB_CDEF);
		send_with_gap(i2a_pkg::OP_HEXL, 32'h0123_4567);
		send_with_gap(i2a_pkg::OP_HEXU, 32'h0000_0000);
		send_with_gap(i2a_pkg::OP_HEXU, 32'hFFFF_FFFF);
		send_with_gap(i2a_pkg::OP_HEXU, 32'hA5A5_A5A5);
		send_with_gap(i2a_pkg::OP_HEXU, 32'h5A5A_5A5A);
		drain_pause();

		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			send_with_gap(2'($urandom_range(0, 3)), pick_value());
			if (i == 60 || i == 240) begin
				drain_pause();
			end
		end

		s_tvalid <= 1'b0;
		while (chars_pending != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Summary: %0d numbers converted across all four modes, %0d characters checked,",
			numbers_seen, chars_seen);
		$display("including a long output stall and drained pauses on the input side.");
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// The receiver stalls at random, runs free in some stretches and holds off once for long.
	initial begin
		int cycle_count;
		int hold_left;
		int stall_left;
		int r;
		logic ready_next;
		cycle_count = 0;
		hold_left   = 0;
		stall_left  = 0;
		forever begin
			@(negedge clk);
			cycle_count++;
			if (cycle_count == HOLD_START) begin
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if ((cycle_count / 400) % 3 == 1) begin
				ready_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				ready_next = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				ready_next = 1'b0;
				if (r < 60) begin
					ready_next = 1'b1;
				end else if (r < 90) begin
					stall_left = $urandom_range(0, 2);
				end else if (r < 98) begin
					stall_left = $urandom_range(3, 9);
				end else begin
					stall_left = $urandom_range(19, 49);
				end
			end
			m_tready <= ready_next;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
